>>> rtl/cisd_pkg.sv
package cisd_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int RING_W      = $clog2(RING_DEPTH);
    localparam int SITE_SLOTS  = 4096;
    localparam int SITE_W      = $clog2(SITE_SLOTS);
    localparam int PROBE_LIMIT = 64;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

    localparam logic [31:0] HASH_K     = 32'd2654435761;
    localparam logic [3:0]  PERIOD_MAX = 4'd8;
    localparam logic [47:0] MAX48      = 48'hffff_ffff_ffff;
    localparam logic [31:0] MAX32      = 32'hffff_ffff;

    localparam logic [1:0] CMD_DATA_READ = 2'd0;
    localparam logic [1:0] CMD_MEM_WRITE = 2'd1;
    localparam logic [1:0] CMD_OPCODE    = 2'd2;
    localparam logic [1:0] CMD_SITE_READ = 2'd3;

    localparam logic [2:0] REG_MAX_PERIOD = 3'd0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] addr;
        logic [23:0] pc;
        logic [15:0] reg_a;
        logic [15:0] reg_x;
        logic [15:0] reg_y;
        logic [15:0] stack_ptr;
        logic [15:0] direct_page;
        logic [7:0]  data_bank;
        logic [7:0]  status_flags;
        logic        emulation;
    } in_item_t;

    typedef struct packed {
        logic        spin_hit;
        logic        io_spin;
        logic [3:0]  loop_period;
        logic [47:0] op_count;
        logic [47:0] pure_count;
        logic [47:0] io_count;
        logic [23:0] site_pc;
        logic [31:0] site_iters;
        logic [3:0]  site_period;
        logic        site_io;
        logic [23:0] site_addr;
    } out_item_t;

    typedef struct packed {
        logic [23:0] pc;
        logic [31:0] iters;
        logic [3:0]  period;
        logic        io;
        logic [23:0] addr;
    } site_slot_t;

    typedef struct packed {
        logic [23:0] pc;
        logic [63:0] regs_low;
        logic [40:0] regs_high;
        logic [15:0] write_mark;
        logic [15:0] io_mark;
    } ring_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RING_RD,
        ST_RING_CMP,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_SLOT_RD,
        ST_RING_WR,
        ST_RESP
    } state_t;

    function automatic logic [47:0] sat48_inc(input logic [47:0] v);
        return (v == MAX48) ? MAX48 : v + 48'd1;
    endfunction

endpackage

>>> rtl/cisd_ram.sv
module cisd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/cpu_idle_spin_detector_top.sv
// Idle-spin detector for a 65816 trace.
// Requests enter on s_valid/s_ready with payload s_data (cmd, addr, pc and
// the register snapshot); one result leaves per request on m_valid/m_ready
// with payload m_data. max_period is written over the APB port at address 0.
// One request is worked on at a time; the result sits in an output register,
// so the next request is taken while an earlier result waits for m_ready.
// Steps per request, from accept to result ready:
//   data read, memory write: none between accept and result
//   site slot read: one site table read
//   opcode: one ring memory read per ring entry scanned (up to max_period,
//   at most 8, once the ring is full), then on a hit one site table read per
//   slot probed (up to 64), then the ring write.
// After reset the site table is swept to zero, one slot a cycle, across all
// 4096 slots; s_ready stays low during that pass. Config writes are taken always.
// A stalled m_ready holds the result and blocks the following request at its
// last step only.
module cpu_idle_spin_detector_top
    import cisd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    in_item_t          req_reg, req_next;
    logic [3:0]        d_reg, d_next;
    logic [SITE_W-1:0] probe_h_reg, probe_h_next;
    logic [PROBE_W-1:0] probe_n_reg, probe_n_next;
    logic [SITE_W-1:0] clr_reg, clr_next;
    logic              hit_reg, hit_next;
    logic              io_reg, io_next;
    logic [3:0]        period_reg, period_next;
    site_slot_t        site_reg, site_next;
    logic [15:0]       wcnt_reg, wcnt_next;
    logic [15:0]       iocnt_reg, iocnt_next;
    logic [23:0]       last_addr_reg, last_addr_next;
    logic [47:0]       total_reg, total_next;
    logic [47:0]       pure_reg, pure_next;
    logic [47:0]       ioops_reg, ioops_next;
    logic [RING_W-1:0] head_reg, head_next;
    logic [RING_W:0]   fill_reg, fill_next;
    logic [3:0]        max_period_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              ring_we;
    logic [RING_W-1:0] ring_raddr;
    ring_entry_t       ring_wentry;
    logic [$bits(ring_entry_t)-1:0] ring_rdata;
    ring_entry_t       ring_rentry;

    logic              site_we;
    logic [SITE_W-1:0] site_waddr, site_raddr;
    site_slot_t        site_wslot;
    logic [$bits(site_slot_t)-1:0] site_rdata;
    site_slot_t        site_rslot;

    logic              accept;
    logic              out_free;
    logic [3:0]        lim;
    logic              ring_full;
    logic              pc_match;
    logic              regs_same;
    logic              slot_ok;
    logic [SITE_W-1:0] hash_idx;
    logic [63:0]       snap_low;
    logic [40:0]       snap_high;
    logic              near_pc;
    logic              is_wram, is_rom;
    logic [7:0]        rd_bank;
    logic [15:0]       rd_off;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign lim       = (max_period_reg > PERIOD_MAX) ? PERIOD_MAX : max_period_reg;
    assign ring_full = (fill_reg == (RING_W + 1)'(RING_DEPTH));

    assign ring_rentry = ring_entry_t'(ring_rdata);
    assign site_rslot  = site_slot_t'(site_rdata);

    assign snap_low  = {req_reg.stack_ptr, req_reg.reg_y, req_reg.reg_x, req_reg.reg_a};
    assign snap_high = {req_reg.emulation, req_reg.status_flags, req_reg.data_bank,
                        req_reg.pc[23:16], req_reg.direct_page};

    assign pc_match  = (ring_rentry.pc == req_reg.pc);
    assign regs_same = (ring_rentry.regs_low == snap_low) &&
                       (ring_rentry.regs_high == snap_high) &&
                       (ring_rentry.write_mark == wcnt_reg);
    assign slot_ok   = (site_rslot.pc == req_reg.pc) || (site_rslot.pc == 24'd0);
    assign hash_idx  = SITE_W'(req_reg.pc[SITE_W-1:0] * HASH_K[SITE_W-1:0]);

    // Data read classification; bounds do not wrap at 24 bits.
    assign near_pc = ({1'b0, s_data.pc} <= {1'b0, s_data.addr} + 25'd6) &&
                     ({1'b0, s_data.addr} <= {1'b0, s_data.pc} + 25'd6);
    assign rd_bank = s_data.addr[23:16];
    assign rd_off  = s_data.addr[15:0];
    assign is_wram = (rd_bank == 8'h7e) || (rd_bank == 8'h7f) ||
                     ((rd_off < 16'h2000) &&
                      ((rd_bank < 8'h40) || ((rd_bank >= 8'h80) && (rd_bank < 8'hc0))));
    assign is_rom  = (rd_off >= 16'h8000) || ((rd_bank >= 8'h40) && (rd_bank < 8'h7e)) ||
                     (rd_bank >= 8'hc0);

    cisd_ram #(
        .WIDTH ($bits(ring_entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (head_reg),
        .wdata (ring_wentry),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    cisd_ram #(
        .WIDTH ($bits(site_slot_t)),
        .DEPTH (SITE_SLOTS)
    ) u_site_ram (
        .aclk  (aclk),
        .we    (site_we),
        .waddr (site_waddr),
        .wdata (site_wslot),
        .raddr (site_raddr),
        .rdata (site_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == SITE_W'(SITE_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.cmd)
                        CMD_DATA_READ, CMD_MEM_WRITE: state_next = ST_RESP;
                        CMD_OPCODE: begin
                            state_next = (ring_full && (lim != 4'd0)) ? ST_RING_RD
                                                                      : ST_RING_WR;
                        end
                        CMD_SITE_READ: state_next = ST_SLOT_RD;
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_RING_RD:  state_next = ST_RING_CMP;
            ST_RING_CMP: begin
                if (pc_match) begin
                    state_next = regs_same ? ST_PROBE_RD : ST_RING_WR;
                end else if (d_reg == lim) begin
                    state_next = ST_RING_WR;
                end else begin
                    state_next = ST_RING_RD;
                end
            end
            ST_PROBE_RD: state_next = ST_PROBE_CHK;
            ST_PROBE_CHK: begin
                if (slot_ok || (probe_n_reg == PROBE_W'(PROBE_LIMIT - 1))) begin
                    state_next = ST_RING_WR;
                end else begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_SLOT_RD: state_next = ST_RESP;
            ST_RING_WR: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        req_next       = req_reg;
        d_next         = d_reg;
        probe_h_next   = probe_h_reg;
        probe_n_next   = probe_n_reg;
        clr_next       = clr_reg;
        hit_next       = hit_reg;
        io_next        = io_reg;
        period_next    = period_reg;
        site_next      = site_reg;
        wcnt_next      = wcnt_reg;
        iocnt_next     = iocnt_reg;
        last_addr_next = last_addr_reg;
        total_next     = total_reg;
        pure_next      = pure_reg;
        ioops_next     = ioops_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        ring_we     = 1'b0;
        ring_raddr  = head_reg - RING_W'(d_reg);
        ring_wentry = '{pc: req_reg.pc, regs_low: snap_low, regs_high: snap_high,
                        write_mark: wcnt_reg, io_mark: iocnt_reg};

        site_we    = 1'b0;
        site_waddr = probe_h_reg;
        site_raddr = probe_h_reg;
        site_wslot = '{pc: req_reg.pc,
                       iters: (site_rslot.iters == MAX32) ? MAX32
                                                          : site_rslot.iters + 32'd1,
                       period: period_reg, io: io_reg, addr: last_addr_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                site_we    = 1'b1;
                site_waddr = clr_reg;
                site_wslot = '0;
                clr_next   = clr_reg + SITE_W'(1);
            end
            ST_IDLE: begin
                site_raddr = s_data.addr[SITE_W-1:0];
                if (accept) begin
                    req_next    = s_data;
                    d_next      = 4'd1;
                    hit_next    = 1'b0;
                    io_next     = 1'b0;
                    period_next = 4'd0;
                    site_next   = '0;
                    unique case (s_data.cmd)
                        CMD_DATA_READ: begin
                            if (!near_pc) begin
                                last_addr_next = s_data.addr;
                                if (!is_wram && !is_rom) begin
                                    iocnt_next = iocnt_reg + 16'd1;
                                end
                            end
                        end
                        CMD_MEM_WRITE: wcnt_next = wcnt_reg + 16'd1;
                        CMD_OPCODE:    total_next = sat48_inc(total_reg);
                        default: ;
                    endcase
                end
            end
            ST_RING_CMP: begin
                if (pc_match) begin
                    if (regs_same) begin
                        hit_next     = 1'b1;
                        io_next      = (ring_rentry.io_mark != iocnt_reg);
                        period_next  = d_reg;
                        probe_h_next = hash_idx;
                        probe_n_next = '0;
                        if (ring_rentry.io_mark != iocnt_reg) begin
                            ioops_next = sat48_inc(ioops_reg);
                        end else begin
                            pure_next = sat48_inc(pure_reg);
                        end
                    end
                end else begin
                    d_next = d_reg + 4'd1;
                end
            end
            ST_PROBE_CHK: begin
                if (slot_ok) begin
                    site_we = 1'b1;
                end else begin
                    probe_h_next = probe_h_reg + SITE_W'(1);
                    probe_n_next = probe_n_reg + PROBE_W'(1);
                end
            end
            ST_SLOT_RD: begin
                site_next = site_rslot;
            end
            ST_RING_WR: begin
                ring_we   = 1'b1;
                head_next = head_reg + RING_W'(1);
                if (!ring_full) begin
                    fill_next = fill_reg + (RING_W + 1)'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{spin_hit: hit_reg, io_spin: io_reg,
                                     loop_period: period_reg, op_count: total_reg,
                                     pure_count: pure_reg, io_count: ioops_reg,
                                     site_pc: site_reg.pc, site_iters: site_reg.iters,
                                     site_period: site_reg.period, site_io: site_reg.io,
                                     site_addr: site_reg.addr};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            wcnt_reg       <= '0;
            iocnt_reg      <= '0;
            last_addr_reg  <= '0;
            total_reg      <= '0;
            pure_reg       <= '0;
            ioops_reg      <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
            max_period_reg <= PERIOD_MAX;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wcnt_reg      <= wcnt_next;
            iocnt_reg     <= iocnt_next;
            last_addr_reg <= last_addr_next;
            total_reg     <= total_next;
            pure_reg      <= pure_next;
            ioops_reg     <= ioops_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
            if (psel && penable && pwrite && (paddr == REG_MAX_PERIOD)) begin
                max_period_reg <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        d_reg       <= d_next;
        probe_h_reg <= probe_h_next;
        probe_n_reg <= probe_n_next;
        hit_reg     <= hit_next;
        io_reg      <= io_next;
        period_reg  <= period_next;
        site_reg    <= site_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr == REG_MAX_PERIOD) ? {28'd0, max_period_reg} : 32'd0;

endmodule

>>> rtl/cisd_checker.sv
module cisd_checker
    import cisd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // One request in flight: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    a_no_hit_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.spin_hit) |-> (!m_data.io_spin && m_data.loop_period == 4'd0))
        else $error("hit fields set without a hit");

    a_hit_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.spin_hit) |->
            (m_data.loop_period != 4'd0 && m_data.loop_period <= PERIOD_MAX))
        else $error("hit period out of range");

endmodule

bind cpu_idle_spin_detector_top cisd_checker u_cisd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import cisd_pkg::*;

    localparam int STALL_LIMIT = 30000;
    localparam int DRAIN_CYCLES = 200;
    localparam int IN_W = $bits(in_item_t);

    typedef struct packed {
        in_item_t    snap;
        logic [15:0] write_mark;
        logic [15:0] io_mark;
    } trace_entry_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cpu_idle_spin_detector_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    trace_entry_t trace_ring [RING_DEPTH];
    site_slot_t   spin_sites [SITE_SLOTS];
    logic [3:0]   ring_wr_ptr;
    int           ring_count;
    logic [15:0]  writes_seen;
    logic [15:0]  io_reads_seen;
    logic [23:0]  last_read_addr;
    logic [47:0]  ops_total;
    logic [47:0]  ops_pure;
    logic [47:0]  ops_io;
    logic [3:0]   period_limit;

    in_item_t  reqs_pending [$];
    out_item_t results_due [$];
    int        mismatches;
    int        send_gap;
    int        recv_stall;
    bit        send_quiet;
    bit        recv_quiet;
    int        idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [11:0] site_hash(input logic [23:0] pc);
        logic [31:0] h;
        h = {8'd0, pc} * HASH_K;
        return h[11:0];
    endfunction

    function automatic bit is_io_addr(input logic [23:0] a);
        logic [7:0]  bank;
        logic [15:0] off;
        bank = a[23:16];
        off = a[15:0];
        if (bank == 8'h7e || bank == 8'h7f) return 0;
        if (off < 16'h2000 && (bank < 8'h40 || (bank >= 8'h80 && bank < 8'hc0))) return 0;
        if (off >= 16'h8000 || (bank >= 8'h40 && bank < 8'h7e) || bank >= 8'hc0) return 0;
        return 1;
    endfunction

    function automatic logic [47:0] sat_inc48(input logic [47:0] v);
        return (v == MAX48) ? v : v + 48'd1;
    endfunction

    function automatic void record_site(input logic [23:0] pc, input logic [3:0] per,
                                        input logic io);
        logic [11:0] h;
        h = site_hash(pc);
        for (int i = 0; i < PROBE_LIMIT; i++) begin
            if (spin_sites[h].pc == pc || spin_sites[h].pc == 24'd0) begin
                spin_sites[h].pc = pc;
                if (spin_sites[h].iters != MAX32) spin_sites[h].iters++;
                spin_sites[h].period = per;
                spin_sites[h].io = io;
                spin_sites[h].addr = last_read_addr;
                return;
            end
            h = h + 12'd1;
        end
    endfunction

    function automatic out_item_t spin_predict(input in_item_t r);
        out_item_t    res;
        trace_entry_t e;
        logic [3:0]   k;
        int           lim;
        int unsigned  a32;
        int unsigned  p32;
        res = '0;
        case (r.cmd)
            CMD_DATA_READ: begin
                a32 = 32'(r.addr);
                p32 = 32'(r.pc);
                // skip operand fetches near the program counter
                if (!(p32 <= a32 + 6 && a32 <= p32 + 6)) begin
                    last_read_addr = r.addr;
                    if (is_io_addr(r.addr)) io_reads_seen++;
                end
            end
            CMD_MEM_WRITE: writes_seen++;
            CMD_OPCODE: begin
                e.snap = r;
                e.snap.cmd = '0;
                e.snap.addr = '0;
                e.write_mark = writes_seen;
                e.io_mark = io_reads_seen;
                ops_total = sat_inc48(ops_total);
                lim = int'((period_limit > PERIOD_MAX) ? PERIOD_MAX : period_limit);
                if (ring_count >= RING_DEPTH) begin
                    for (int d = 1; d <= lim; d++) begin
                        k = ring_wr_ptr - 4'(d);
                        if (trace_ring[k].snap.pc != r.pc) continue;
                        if (trace_ring[k].snap == e.snap && trace_ring[k].write_mark == writes_seen)
                        begin
                            res.spin_hit = 1'b1;
                            res.io_spin = trace_ring[k].io_mark != io_reads_seen;
                            res.loop_period = 4'(d);
                            if (res.io_spin) ops_io = sat_inc48(ops_io);
                            else ops_pure = sat_inc48(ops_pure);
                            record_site(r.pc, 4'(d), res.io_spin);
                        end
                        break;
                    end
                end
                trace_ring[ring_wr_ptr] = e;
                ring_wr_ptr++;
                if (ring_count < RING_DEPTH) ring_count++;
            end
            default: begin
                res.site_pc = spin_sites[r.addr[11:0]].pc;
                res.site_iters = spin_sites[r.addr[11:0]].iters;
                res.site_period = spin_sites[r.addr[11:0]].period;
                res.site_io = spin_sites[r.addr[11:0]].io;
                res.site_addr = spin_sites[r.addr[11:0]].addr;
            end
        endcase
        res.op_count = ops_total;
        res.pure_count = ops_pure;
        res.io_count = ops_io;
        return res;
    endfunction

    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(spin_predict(s_data));
                send_gap = draw_gap(send_quiet);
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && reqs_pending.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= reqs_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_data);
                end else begin
                    want = results_due.pop_front();
                    if (want.spin_hit !== m_data.spin_hit || want.io_spin !== m_data.io_spin
                        || want.loop_period !== m_data.loop_period
                        || want.op_count !== m_data.op_count
                        || want.pure_count !== m_data.pure_count
                        || want.io_count !== m_data.io_count
                        || want.site_pc !== m_data.site_pc
                        || want.site_iters !== m_data.site_iters
                        || want.site_period !== m_data.site_period
                        || want.site_io !== m_data.site_io
                        || want.site_addr !== m_data.site_addr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, m_data);
                    end
                end
                recv_stall = draw_gap(recv_quiet);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_ready <= (recv_stall == 0);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("cpu_idle_spin_detector_top regression: fail");
                $finish;
            end
        end
    end

    function automatic in_item_t rand_req(input logic [1:0] cmd);
        in_item_t r;
        r = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r.cmd = cmd;
        return r;
    endfunction

    function automatic void push_read(input logic [23:0] a, input logic [23:0] pc);
        in_item_t r;
        r = rand_req(CMD_DATA_READ);
        r.addr = a;
        r.pc = pc;
        reqs_pending.push_back(r);
    endfunction

    function automatic void push_site_read(input logic [23:0] a);
        in_item_t r;
        r = rand_req(CMD_SITE_READ);
        r.addr = a;
        reqs_pending.push_back(r);
    endfunction

    function automatic logic [23:0] io_address();
        return {8'($urandom_range(0, 63)), 16'($urandom_range(16'h2000, 16'h7fff))};
    endfunction

    // well-formed spin loops with random content, plus noise
    function automatic void spin_traffic(input int n);
        in_item_t body [10];
        int       per;
        int       iters;
        int       mode;
        while (n > 0) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                reqs_pending.push_back(rand_req(2'($urandom_range(0, 3))));
                n--;
                continue;
            end
            per = (mode == 1) ? $urandom_range(9, 10) : $urandom_range(1, 8);
            iters = $urandom_range(2, 5);
            for (int j = 0; j < per; j++) begin
                body[j] = rand_req(CMD_OPCODE);
                if ($urandom_range(0, 9) == 0) body[j].pc = '0;
                else if ($urandom_range(0, 4) == 0) body[j].pc = body[0].pc;
            end
            for (int it = 0; it < iters; it++) begin
                for (int j = 0; j < per; j++) begin
                    if ($urandom_range(0, 29) == 0) body[j].reg_a ^= 16'($urandom);
                    reqs_pending.push_back(body[j]);
                    n--;
                    case ($urandom_range(0, 11))
                        0, 1: begin
                            push_read(io_address(), body[j].pc);
                            n--;
                        end
                        2: begin
                            push_read(24'($urandom), body[j].pc);
                            n--;
                        end
                        3: begin
                            push_read(body[j].pc + 24'($urandom_range(0, 7)), body[j].pc);
                            n--;
                        end
                        4: begin
                            if ($urandom_range(0, 2) == 0) begin
                                reqs_pending.push_back(rand_req(CMD_MEM_WRITE));
                                n--;
                            end
                        end
                        5: begin
                            push_site_read({12'($urandom), site_hash(body[j].pc)});
                            n--;
                        end
                        default: ;
                    endcase
                end
            end
        end
    endfunction

    task automatic wait_idle();
        while (reqs_pending.size() > 0 || s_valid || results_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_period(input logic [3:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * REG_MAX_PERIOD);
        pwdata <= {28'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        period_limit = v;
    endtask

    initial begin
        in_item_t r;
        in_item_t loop_op;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        mismatches = 0;
        send_gap = 0;
        recv_stall = 0;
        send_quiet = 0;
        recv_quiet = 0;
        ring_wr_ptr = '0;
        ring_count = 0;
        writes_seen = '0;
        io_reads_seen = '0;
        last_read_addr = '0;
        ops_total = '0;
        ops_pure = '0;
        ops_io = '0;
        period_limit = PERIOD_MAX;
        foreach (spin_sites[i]) spin_sites[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // fetch vicinity edges, memory map corners, writes, slot reads
        push_read(24'h001006, 24'h001000);
        push_read(24'h001007, 24'h001000);
        push_read(24'h000ffa, 24'h001000);
        push_read(24'h000ff9, 24'h001000);
        push_read(24'h000000, 24'h000003);
        push_read(24'hffffff, 24'hfffffe);
        push_read(24'h002100, 24'h808000);
        push_read(24'h7e2100, 24'h808000);
        push_read(24'h801fff, 24'h008000);
        push_read(24'h3f8000, 24'h008000);
        push_read(24'hbf4016, 24'h008000);
        push_read(24'hc04016, 24'h008000);
        reqs_pending.push_back(rand_req(CMD_MEM_WRITE));
        push_site_read(24'h000000);
        push_site_read(24'hffffff);
        r = '1;
        r.cmd = CMD_OPCODE;
        reqs_pending.push_back(r);
        r = '0;
        r.cmd = CMD_OPCODE;
        reqs_pending.push_back(r);
        for (int i = 0; i < RING_DEPTH; i++) reqs_pending.push_back(rand_req(CMD_OPCODE));
        // spin at PC zero lands in an empty-looking slot
        loop_op = rand_req(CMD_OPCODE);
        loop_op.pc = '0;
        repeat (3) reqs_pending.push_back(loop_op);
        push_site_read({12'd0, site_hash(24'd0)});
        // colliding PCs overflow the probe window
        for (int j = 1; j <= PROBE_LIMIT + 4; j++) begin
            loop_op = rand_req(CMD_OPCODE);
            loop_op.pc = 24'(j) << 12 | 24'h123;
            repeat (2) reqs_pending.push_back(loop_op);
        end
        for (int j = 0; j < 4; j++) push_site_read({12'd0, site_hash(24'h001123) + 12'(j * 21)});
        push_site_read({12'd0, site_hash(24'h001123) + 12'(PROBE_LIMIT)});
        spin_traffic(150);
        wait_idle();

        write_max_period(4'd1);
        spin_traffic(220);
        wait_idle();
        write_max_period(4'd0);
        spin_traffic(150);
        wait_idle();
        write_max_period(4'd15);
        spin_traffic(280);
        wait_idle();
        write_max_period(4'd3);
        spin_traffic(190);
        wait_idle();
        write_max_period(4'd8);
        spin_traffic(190);
        wait_idle();

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("cpu_idle_spin_detector_top regression: pass");
        end else begin
            $display("cpu_idle_spin_detector_top regression: fail");
        end
        $finish;
    end

endmodule
